// File: hdl/ipv4p_pkg.sv
// Shared types and character constants for the IPv4 dotted address parser.
package ipv4p_pkg;

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  typedef struct packed {
    logic       is_nul;
    logic       is_dot;
    logic       is_space;
    logic       is_dig;
    logic       is_hex_letter;
    logic       is_x;
    logic [3:0] val;
  } char_class_t;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UF    = 8'd70;
  localparam logic [7:0] CH_UX    = 8'd88;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LF    = 8'd102;
  localparam logic [7:0] CH_LX    = 8'd120;

  localparam int unsigned NUM_STORED = 3;

endpackage

// File: hdl/ipv4p_class.sv
// Character classifier: digit, hex letter, separator and digit value.
module ipv4p_class (
  input  logic [7:0]               ch,
  output ipv4p_pkg::char_class_t   cls
);

  logic [7:0] dval;
  logic [7:0] uval;
  logic [7:0] lval;
  logic       is_upper;
  logic       is_lower;

  always_comb begin
    dval     = ch - ipv4p_pkg::CH_0;
    uval     = ch - ipv4p_pkg::CH_UA + 8'd10;
    lval     = ch - ipv4p_pkg::CH_LA + 8'd10;
    is_upper = (ch >= ipv4p_pkg::CH_UA) && (ch <= ipv4p_pkg::CH_UF);
    is_lower = (ch >= ipv4p_pkg::CH_LA) && (ch <= ipv4p_pkg::CH_LF);

    cls.is_nul        = (ch == ipv4p_pkg::CH_NUL);
    cls.is_dot        = (ch == ipv4p_pkg::CH_DOT);
    cls.is_space      = (ch == ipv4p_pkg::CH_SPACE) ||
                        ((ch >= ipv4p_pkg::CH_TAB) && (ch <= ipv4p_pkg::CH_CR));
    cls.is_dig        = (ch >= ipv4p_pkg::CH_0) && (ch <= ipv4p_pkg::CH_9);
    cls.is_hex_letter = is_upper || is_lower;
    cls.is_x          = (ch == ipv4p_pkg::CH_LX) || (ch == ipv4p_pkg::CH_UX);

    if (is_upper) begin
      cls.val = uval[3:0];
    end else if (is_lower) begin
      cls.val = lval[3:0];
    end else begin
      cls.val = dval[3:0];
    end
  end

endmodule

// File: hdl/ipv4p_core.sv
// Parser state, per-character update and address assembly.
module ipv4p_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  ipv4p_pkg::char_class_t   cls,
  output logic                     emit,
  output logic                     ok,
  output logic [31:0]              address
);

  ipv4p_pkg::phase_t phase_r, phase_nxt;
  ipv4p_pkg::radix_t radix_r, radix_nxt;
  ipv4p_pkg::radix_t eff_radix;
  logic [31:0]       accum_r, accum_nxt;
  logic [1:0]        count_r, count_nxt;
  logic [31:0]       store_r [ipv4p_pkg::NUM_STORED];
  logic              store_we;

  logic [31:0] acc_step;
  logic        is_digit_here;
  logic        range_ok;
  logic [31:0] assembled;
  logic        good;
  logic        bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ipv4p_pkg::PH_START;
      radix_r <= ipv4p_pkg::RX_DEC;
      accum_r <= '0;
      count_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      accum_r <= accum_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && store_we) begin
      store_r[count_r] <= accum_r;
    end
  end

  // accum * radix + digit value
  always_comb begin
    eff_radix = (phase_r == ipv4p_pkg::PH_ZERO) ? ipv4p_pkg::RX_OCT : radix_r;
    case (eff_radix)
      ipv4p_pkg::RX_OCT: acc_step = (accum_r << 3) + {28'd0, cls.val};
      ipv4p_pkg::RX_HEX: acc_step = (accum_r << 4) + {28'd0, cls.val};
      default:           acc_step = (accum_r << 3) + (accum_r << 1) + {28'd0, cls.val};
    endcase
    is_digit_here = cls.is_dig || ((eff_radix == ipv4p_pkg::RX_HEX) && cls.is_hex_letter);
  end

  always_comb begin
    case (count_r)
      2'd1: begin
        range_ok  = (accum_r[31:24] == 8'd0);
        assembled = accum_r | (store_r[0] << 24);
      end
      2'd2: begin
        range_ok  = (accum_r[31:16] == 16'd0);
        assembled = accum_r | (store_r[0] << 24) | (store_r[1] << 16);
      end
      2'd3: begin
        range_ok  = (accum_r[31:8] == 24'd0);
        assembled = accum_r | (store_r[0] << 24) | (store_r[1] << 16) | (store_r[2] << 8);
      end
      default: begin
        range_ok  = 1'b1;
        assembled = accum_r;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    accum_nxt = accum_r;
    count_nxt = count_r;
    store_we  = 1'b0;
    good      = 1'b0;
    bad       = 1'b0;

    unique case (phase_r)
      ipv4p_pkg::PH_START: begin
        if (!cls.is_dig) begin
          bad = 1'b1;
        end else begin
          accum_nxt = {28'd0, cls.val};
          radix_nxt = ipv4p_pkg::RX_DEC;
          phase_nxt = (cls.val == 4'd0) ? ipv4p_pkg::PH_ZERO : ipv4p_pkg::PH_DIGIT;
        end
      end
      ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGIT: begin
        phase_nxt = ipv4p_pkg::PH_DIGIT;
        if (phase_r == ipv4p_pkg::PH_ZERO) begin
          radix_nxt = cls.is_x ? ipv4p_pkg::RX_HEX : ipv4p_pkg::RX_OCT;
        end
        if ((phase_r == ipv4p_pkg::PH_ZERO) && cls.is_x) begin
          accum_nxt = accum_r;
        end else if (is_digit_here) begin
          accum_nxt = acc_step;
        end else if (cls.is_dot) begin
          if (count_r == 2'd3) begin
            bad = 1'b1;
          end else begin
            store_we  = 1'b1;
            count_nxt = count_r + 2'd1;
            phase_nxt = ipv4p_pkg::PH_START;
            radix_nxt = ipv4p_pkg::RX_DEC;
            accum_nxt = '0;
          end
        end else if (!cls.is_nul && !cls.is_space) begin
          bad = 1'b1;
        end else if (range_ok) begin
          good = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      ipv4p_pkg::PH_DONE: begin
        if (cls.is_nul) begin
          phase_nxt = ipv4p_pkg::PH_START;
          radix_nxt = ipv4p_pkg::RX_DEC;
          accum_nxt = '0;
          count_nxt = '0;
        end
      end
      default: phase_nxt = ipv4p_pkg::PH_START;
    endcase

    if (good || bad) begin
      if (cls.is_nul) begin
        phase_nxt = ipv4p_pkg::PH_START;
        radix_nxt = ipv4p_pkg::RX_DEC;
        accum_nxt = '0;
        count_nxt = '0;
      end else begin
        phase_nxt = ipv4p_pkg::PH_DONE;
      end
    end
  end

  assign emit    = good || bad;
  assign ok      = good;
  assign address = good ? assembled : 32'd0;

endmodule

// File: hdl/ipv4_dotted_address_parser.sv
// Top level of the IPv4 dotted address parser: input and result registers.
// Takes one character per item and sustains one item per clock unless
// a result is stalled in the output register. A character is held in
// the input register and then updates the parser state; a result (ok
// plus 32-bit address, first part in the top byte of a dotted form) is
// then registered in the output register and shown on out_valid.
// Decimal, octal (leading 0) and hex (leading 0x) parts are accepted
// in the a, a.b, a.b.c and a.b.c.d forms; NUL or whitespace ends a
// string. After a result, characters are dropped until a NUL, which
// rearms the parser. The held character waits, and input is stalled,
// while a result sits in the output register and out_ready is low.
module ipv4_dotted_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_address
);

  logic                   in_v_r;
  logic [7:0]             in_ch_r;
  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [31:0]            out_address_r;
  logic                   proc_en;
  logic                   emit;
  logic                   ok;
  logic [31:0]            address;
  ipv4p_pkg::char_class_t cls;

  assign proc_en  = in_v_r && (!out_valid_r || out_ready);
  assign in_ready = !in_v_r || proc_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_ch_r <= in_ch;
    end
  end

  ipv4p_class u_class (
    .ch  (in_ch_r),
    .cls (cls)
  );

  ipv4p_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (proc_en),
    .cls     (cls),
    .emit    (emit),
    .ok      (ok),
    .address (address)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && emit) begin
      out_ok_r      <= ok;
      out_address_r <= address;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_address = out_address_r;

endmodule
